### rtl/core/ole_pkg.sv
// request/result types and operation codes for the ordered list engine
`default_nettype none

package ole_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_FIND       = 3'd3;
    localparam logic [2:0] OP_REMOVE     = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;
    localparam logic [2:0] OP_DUMP       = 3'd6;

    // a dump emits at most this many results
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [3:0]         position;
        logic signed [31:0] out_value;
        logic [4:0]         occupancy;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/ordered_list_engine_top.sv
// ordered list engine: bounded list of signed 32-bit values; insert keeps sorted order
//
// Requests arrive on req/req_valid/req_stall, results leave on
// res/res_valid/res_stall; a request or result moves when valid is high and
// stall is low. One request is worked on at a time: req_stall stays high from
// the cycle after a request is taken until its last result is loaded into the
// output register, which may still be waiting while the next request enters.
// The elements live in a single-port-read, single-port-write memory with a
// registered read; one comparator scans it one element per cycle.
// Insert first scans for the first element greater than the new value; push and
// insert then shift the elements from the insertion point one place toward the
// tail and write the new value. Find and remove scan from the head, remove then
// closes the gap, and clear and rejected requests go straight to the result.
// Scans and shifts read one element per cycle; dump reads and emits one element
// at a time (at most 16 results). Reset empties the list and drops any waiting
// result; the memory itself is not cleared, entries beyond the count are never
// read. While a valid result is stalled the result register holds and the
// sequencer waits before loading the next result.
`default_nettype none

module ordered_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    input  wire ole_pkg::req_t req,
    output logic              res_valid,
    input  wire logic         res_stall,
    output ole_pkg::res_t     res
);
    import ole_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = CW + 5;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_SHIFT_UP = 8'b0000_0100,
        S_SHIFT_DN = 8'b0000_1000,
        S_PUT      = 8'b0001_0000,
        S_DUMP_RD  = 8'b0010_0000,
        S_DUMP_OUT = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    // element memory
    logic signed [31:0] mem [CAPACITY];
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [IW-1:0]      mem_raddr;
    logic signed [31:0] mem_rdata_reg;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IW-1:0]      rd_addr_reg, rd_addr_next;
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] val_reg, val_next;
    res_t               pend_reg, pend_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg;

    logic               res_load;
    res_t               res_load_data;
    logic               out_free;
    logic               rd_match;
    logic               rd_last;
    logic               scan_stop;
    logic [CW-1:0]      scan_pos;
    logic [CW-1:0]      idx_dec;
    logic               dump_last;

    function automatic res_t make_res(logic ok, logic [CW-1:0] pos, logic signed [31:0] v,
                                      logic [CW-1:0] occ, logic lst);
        logic [WW-1:0] p_w;
        logic [WW-1:0] o_w;
        res_t          r;
        p_w         = WW'(pos);
        o_w         = WW'(occ);
        r.ok        = ok;
        r.position  = p_w[3:0];
        r.out_value = v;
        r.occupancy = o_w[4:0];
        r.last      = lst;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign out_free  = !res_valid_reg || !res_stall;
    assign rd_match  = (op_reg == OP_INSERT) ? (mem_rdata_reg > val_reg)
                                             : (mem_rdata_reg == val_reg);
    assign rd_last   = (CW'(rd_addr_reg) + CW'(1)) == cnt_reg;
    assign scan_stop = rd_valid_reg && (rd_match || rd_last);
    assign scan_pos  = rd_match ? CW'(rd_addr_reg) : cnt_reg;
    assign idx_dec   = idx_reg - CW'(1);
    assign dump_last = ((WW'(idx_reg) + WW'(1)) == WW'(cnt_reg))
                    || (WW'(idx_reg) == WW'(MAX_RESULTS - 1));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        rd_valid_next = 1'b0;
        rd_addr_next  = rd_addr_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        pend_next     = pend_reg;
        mem_we        = 1'b0;
        mem_waddr     = rd_addr_reg;
        mem_wdata     = mem_rdata_reg;
        mem_re        = 1'b0;
        mem_raddr     = idx_reg[IW-1:0];
        res_load      = 1'b0;
        res_load_data = pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req.req_type;
                    val_next = req.item_value;
                    idx_next = '0;
                    case (req.req_type)
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
                        begin
                            if (cnt_reg == CAP_C)
                            begin
                                pend_next  = make_res(1'b0, '0, '0, cnt_reg, 1'b1);
                                state_next = S_EMIT;
                            end
                            else if (req.req_type == OP_INSERT && cnt_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                pos_next   = (req.req_type == OP_PUSH_BACK) ? cnt_reg : '0;
                                idx_next   = cnt_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_FIND, OP_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_next  = make_res(1'b0, '0, '0, cnt_reg, 1'b1);
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            pend_next  = make_res(1'b1, '0, '0, '0, 1'b1);
                            state_next = S_EMIT;
                        end
                        OP_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_next  = make_res(1'b0, '0, '0, '0, 1'b1);
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            pend_next  = make_res(1'b0, '0, '0, cnt_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read one element per cycle, compare the one read last cycle
                if (!scan_stop && idx_reg < cnt_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = idx_reg[IW-1:0];
                    rd_valid_next = 1'b1;
                    rd_addr_next  = idx_reg[IW-1:0];
                    idx_next      = idx_reg + CW'(1);
                end
                if (scan_stop)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            pos_next   = scan_pos;
                            idx_next   = cnt_reg;
                            state_next = S_SHIFT_UP;
                        end
                        OP_FIND:
                        begin
                            pend_next = rd_match
                                ? make_res(1'b1, scan_pos, val_reg, cnt_reg, 1'b1)
                                : make_res(1'b0, '0, '0, cnt_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                        OP_REMOVE:
                        begin
                            if (rd_match)
                            begin
                                pos_next   = scan_pos;
                                idx_next   = scan_pos + CW'(1);
                                state_next = S_SHIFT_DN;
                            end
                            else
                            begin
                                pend_next  = make_res(1'b0, '0, '0, cnt_reg, 1'b1);
                                state_next = S_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SHIFT_UP:
            begin
                // move elements one place toward the tail, from the tail down
                if (rd_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg + IW'(1);
                    mem_wdata = mem_rdata_reg;
                end
                if (idx_reg > pos_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = idx_dec[IW-1:0];
                    rd_valid_next = 1'b1;
                    rd_addr_next  = idx_dec[IW-1:0];
                    idx_next      = idx_dec;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[IW-1:0];
                mem_wdata  = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                pend_next  = make_res(1'b1, pos_reg, '0, cnt_reg + CW'(1), 1'b1);
                state_next = S_EMIT;
            end

            S_SHIFT_DN:
            begin
                // close the gap left by the removed element
                if (rd_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg - IW'(1);
                    mem_wdata = mem_rdata_reg;
                end
                if (idx_reg < cnt_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = idx_reg[IW-1:0];
                    rd_valid_next = 1'b1;
                    rd_addr_next  = idx_reg[IW-1:0];
                    idx_next      = idx_reg + CW'(1);
                end
                else if (!rd_valid_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    pend_next  = make_res(1'b1, pos_reg, '0, cnt_reg - CW'(1), 1'b1);
                    state_next = S_EMIT;
                end
            end

            S_DUMP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[IW-1:0];
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    res_load      = 1'b1;
                    res_load_data = make_res(1'b1, idx_reg, mem_rdata_reg, cnt_reg, dump_last);
                    idx_next      = idx_reg + CW'(1);
                    state_next    = dump_last ? S_IDLE : S_DUMP_RD;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    res_load      = 1'b1;
                    res_load_data = pend_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid_next = res_load ? 1'b1 : (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            rd_valid_reg  <= rd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        pend_reg    <= pend_next;
        if (res_load)
        begin
            res_reg <= res_load_data;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_C)
        else $error("element count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (cnt_reg == $past(cnt_reg) + CW'(1)) || (cnt_reg == $past(cnt_reg) - CW'(1))
            || (cnt_reg == '0))
        else $error("element count changed by more than one");

    a_rd_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |->
            (state_reg == S_SCAN) || (state_reg == S_SHIFT_UP) || (state_reg == S_SHIFT_DN))
        else $error("read pending outside scan or shift");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("request taken but sequencer stayed idle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |-> !res_load)
        else $error("result loaded over a stalled result");

endmodule

`default_nettype wire

### tb/sv/tb_ordered_list_engine_top.sv
// self-checking testbench for the ordered list engine: directed, fill, random and hold-off tests
`timescale 1ns / 100ps

module tb_ordered_list_engine_top;

    import ole_pkg::*;

    localparam int CAPACITY = 16;
    // req_type code the block does not know
    localparam logic [2:0] OP_UNKNOWN = 3'd7;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    // shadow copy of the list, updated when a request is accepted
    logic signed [31:0] list_vals [CAPACITY];
    int list_count = 0;
    res_t expected_results [$];

    bit idle_enable = 1'b1;
    bit stall_enable = 1'b1;
    int hold_off_len = 0;

    int mismatch_count = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int full_rejects = 0;
    int op_count [8];

    ordered_list_engine_top #(.CAPACITY(CAPACITY)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("ordered_list_engine_top test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void expect_result(input logic ok, input int pos,
                                          input logic signed [31:0] val, input logic last);
        res_t e;
        e.ok = ok;
        e.position = pos[3:0];
        e.out_value = val;
        e.occupancy = list_count[4:0];
        e.last = last;
        expected_results.push_back(e);
    endfunction

    function automatic void predict_list_op(input req_t r);
        int slot;
        int i;
        int n;
        bit hit;
        slot = 0;
        hit = 1'b0;
        op_count[r.req_type]++;
        case (r.req_type)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
            begin
                if (list_count >= CAPACITY)
                begin
                    full_rejects++;
                    expect_result(1'b0, 0, '0, 1'b1);
                end
                else
                begin
                    if (r.req_type == OP_PUSH_FRONT)
                        slot = 0;
                    else
                        slot = list_count;
                    // new value goes before the first strictly greater one
                    if (r.req_type == OP_INSERT)
                        for (i = 0; i < list_count; i++)
                            if (!hit && list_vals[i] > r.item_value)
                            begin
                                slot = i;
                                hit = 1'b1;
                            end
                    for (i = list_count; i > slot; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[slot] = r.item_value;
                    list_count++;
                    expect_result(1'b1, slot, '0, 1'b1);
                end
            end
            OP_FIND, OP_REMOVE:
            begin
                for (i = 0; i < list_count; i++)
                    if (!hit && list_vals[i] == r.item_value)
                    begin
                        slot = i;
                        hit = 1'b1;
                    end
                if (!hit)
                    expect_result(1'b0, 0, '0, 1'b1);
                else if (r.req_type == OP_FIND)
                    expect_result(1'b1, slot, list_vals[slot], 1'b1);
                else
                begin
                    for (i = slot; i + 1 < list_count; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_count--;
                    expect_result(1'b1, slot, '0, 1'b1);
                end
            end
            OP_CLEAR:
            begin
                list_count = 0;
                expect_result(1'b1, 0, '0, 1'b1);
            end
            OP_DUMP:
            begin
                if (list_count == 0)
                    expect_result(1'b0, 0, '0, 1'b1);
                else
                begin
                    n = (list_count > MAX_RESULTS) ? MAX_RESULTS : list_count;
                    for (i = 0; i < n; i++)
                        expect_result(1'b1, i, list_vals[i], i + 1 == n);
                end
            end
            default:
                expect_result(1'b0, 0, '0, 1'b1);
        endcase
    endfunction

    // valid stays high between back-to-back requests; dropped only for a gap
    task automatic send_request(input logic [2:0] op, input logic signed [31:0] value);
        req_t r;
        r.req_type = op;
        r.item_value = value;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        requests_sent++;
        predict_list_op(r);
    endtask

    function automatic logic signed [31:0] pick_value();
        int sel;
        int near;
        sel = $urandom_range(0, 9);
        near = $urandom_range(0, 16);
        if (sel < 4 && list_count > 0)
            return list_vals[$urandom_range(0, list_count - 1)];
        else if (sel < 7)
            return near - 8;
        else if (sel == 7)
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) return OP_PUSH_FRONT;
        if (r < 28) return OP_PUSH_BACK;
        if (r < 50) return OP_INSERT;
        if (r < 66) return OP_FIND;
        if (r < 84) return OP_REMOVE;
        if (r < 87) return OP_CLEAR;
        if (r < 97) return OP_DUMP;
        return OP_UNKNOWN;
    endfunction

    // result side stall: random short bursts, or one long hold when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                res_stall <= 1'b0;
            end
            else if (stall_enable && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_checked++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result with nothing expected: %p", res));
            else
            begin
                want = expected_results.pop_front();
                if (res.ok !== want.ok)
                    report_mismatch($sformatf("ok got %b want %b", res.ok, want.ok));
                if (res.position !== want.position)
                    report_mismatch($sformatf("position got %0d want %0d",
                                              res.position, want.position));
                if (res.out_value !== want.out_value)
                    report_mismatch($sformatf("out_value got %0d want %0d",
                                              res.out_value, want.out_value));
                if (res.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy got %0d want %0d",
                                              res.occupancy, want.occupancy));
                if (res.last !== want.last)
                    report_mismatch($sformatf("last got %b want %b", res.last, want.last));
            end
        end
    end

    task automatic test_empty_list();
        send_request(OP_DUMP, 32'sd0);
        send_request(OP_FIND, 32'sd0);
        send_request(OP_REMOVE, 32'sd5);
        send_request(OP_CLEAR, $urandom);
        send_request(OP_UNKNOWN, 32'sh8000_0000);
    endtask

    task automatic test_ordering_extremes();
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, 32'sh7FFF_FFFF);
        send_request(OP_INSERT, 32'sh8000_0000);
        send_request(OP_INSERT, -32'sd1);
        // equal value lands after the one already stored
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_PUSH_FRONT, 32'sd5);
        send_request(OP_PUSH_BACK, -32'sd5);
        send_request(OP_FIND, -32'sd1);
        send_request(OP_FIND, 32'sd123);
        send_request(OP_DUMP, 32'sh7FFF_FFFF);
        send_request(OP_REMOVE, -32'sd1);
        send_request(OP_REMOVE, 32'sh7FFF_FFFF);
        send_request(OP_UNKNOWN, 32'sh7FFF_FFFF);
        send_request(OP_DUMP, 32'sd0);
        send_request(OP_CLEAR, 32'sd0);
        send_request(OP_DUMP, 32'sd0);
    endtask

    // fill to capacity with random content, then hit every insert path on a full list
    task automatic test_fill_and_overflow(input int rounds);
        repeat (rounds)
        begin
            send_request(OP_CLEAR, $urandom);
            while (list_count < CAPACITY)
                send_request(logic'($urandom_range(0, 2)) ? 3'($urandom_range(0, 2)) : OP_INSERT,
                             pick_value());
            send_request(OP_PUSH_FRONT, pick_value());
            send_request(OP_PUSH_BACK, pick_value());
            send_request(OP_INSERT, pick_value());
            send_request(OP_DUMP, $urandom);
            send_request(OP_FIND, list_vals[CAPACITY - 1]);
            send_request(OP_REMOVE, list_vals[$urandom_range(0, CAPACITY - 1)]);
            send_request(OP_INSERT, pick_value());
        end
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_request(pick_op(), pick_value());
    endtask

    task automatic test_receiver_hold();
        hold_off_len = 120;
        repeat (6)
            send_request(OP_PUSH_BACK, pick_value());
        send_request(OP_DUMP, 32'sd0);
        repeat (5)
            send_request(pick_op(), pick_value());
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        while (expected_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        while (expected_results.size() != 0)
            report_mismatch($sformatf("result never arrived: %p", expected_results.pop_front()));
        $display("%0d requests sent, %0d results checked, %0d rejected on a full list",
                 requests_sent, results_checked, full_rejects);
        $display("ops pf/pb/ins/find/rm/clr/dump/unk: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4], op_count[5], op_count[6], op_count[7]);
        if (mismatch_count == 0)
            $display("ordered_list_engine_top test passed");
        else
            $display("ordered_list_engine_top test failed");
        $finish;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_ordering_extremes();
        test_fill_and_overflow(2);
        test_random_mix(70);
        test_receiver_hold();
        // closing stretch runs without gaps or stalls
        idle_enable = 1'b0;
        stall_enable = 1'b0;
        test_random_mix(50);
        finish_run();
    end

endmodule

### ordered_list_engine_top.f
rtl/core/ole_pkg.sv
rtl/core/ordered_list_engine_top.sv
tb/sv/tb_ordered_list_engine_top.sv
